// ===== src/frac_red_pkg.sv =====
// Shared types and constants for the fraction reducer.
`default_nettype none

package frac_red_pkg;

   // Width of the signed numerator and denominator.
   localparam int VALUE_WIDTH = 32;
   // Width of the positive reduced denominator.
   localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
   // Width of the division step counter.
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
   // Counter value on the last division step.
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

   // Fields of one request transaction.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] numerator;
      logic signed [VALUE_WIDTH-1:0] denominator;
   } req_type;

   // Fields of one response transaction.
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] reduced_numerator;
      logic [DEN_WIDTH-1:0]          reduced_denominator;
      logic                          denominator_replaced;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TWOS,
      ST_ODD,
      ST_DIVN,
      ST_SAVEN,
      ST_DIVD,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic twos_shift;
      logic gcd_init;
      logic gcd_step;
      logic div_init_num;
      logic div_init_den;
      logic div_step;
      logic save_num;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mag_zero;
      logic both_even;
      logic gcd_equal;
   } status_type;

endpackage

`default_nettype wire

// ===== src/fraction_reducer.sv =====
// Top level of the fraction reducer: controller plus datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    frac_red_pkg::req_type
//   rsp_      out        rsp_valid/rsp_ready    frac_red_pkg::rsp_type
//
// A transaction loads the operands, strips common factors of two, runs the binary GCD
// steps, starts the GCD and the two divisions, makes two 32-step passes of the shared
// restoring divider and loads the output register. A zero numerator skips the GCD and
// the divisions.
// Reset is synchronous and active high and clears the controller only.
// A new request is taken while the previous response still waits for rsp_ready.
`default_nettype none

module fraction_reducer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire frac_red_pkg::req_type req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output frac_red_pkg::rsp_type      rsp_payload
);

   frac_red_pkg::cmd_type    cmd;
   frac_red_pkg::status_type status;

   frac_red_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   frac_red_dpath u_dpath (
      .clock       (clock),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   // A replaced denominator always reduces to one.
   a_replaced_den_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.denominator_replaced |->
         rsp_payload.reduced_denominator == frac_red_pkg::DEN_WIDTH'(1))
      else $error("replaced denominator did not reduce to one");

   // The reduced denominator is never zero.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.reduced_denominator != '0)
      else $error("reduced denominator is zero");

   // Only one transaction is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // No response is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule

`default_nettype wire

// ===== src/frac_red_dpath.sv =====
// Datapath of the fraction reducer: operand registers, binary GCD and shared divider.
`default_nettype none

module frac_red_dpath (
   input  wire logic                  clock,
   input  wire frac_red_pkg::req_type req_payload,
   input  wire frac_red_pkg::cmd_type cmd,
   output frac_red_pkg::status_type   status,
   output frac_red_pkg::rsp_type      rsp_payload
);

   localparam int W = frac_red_pkg::VALUE_WIDTH;
   localparam int D = frac_red_pkg::DEN_WIDTH;

   logic [W-1:0] mag_ff, mag_in;
   logic [D-1:0] den_ff, den_in;
   logic         neg_ff, neg_in;
   logic         repl_ff, repl_in;
   logic [W-1:0] u_ff, u_in;
   logic [D-1:0] v_ff, v_in;
   logic [W-1:0] quo_ff, quo_in;
   logic [D-1:0] rem_ff, rem_in;
   logic [W-1:0] num_res_ff, num_res_in;
   frac_red_pkg::rsp_type rsp_ff, rsp_in;

   logic [W-1:0] num_bits;
   logic [W-1:0] den_bits;
   logic         den_bad;
   logic [W-1:0] v_wide;
   logic [W-1:0] diff_uv;
   logic [W-1:0] diff_vu;
   logic [W-1:0] trial;
   logic         trial_ge;
   logic [W-1:0] trial_sub;

   // Sign handling and denominator replacement at load time.
   assign num_bits = req_payload.numerator;
   assign den_bits = req_payload.denominator;
   assign den_bad  = (den_bits == '0) || den_bits[W-1];

   // Operands of one GCD step.
   assign v_wide  = {1'b0, v_ff};
   assign diff_uv = u_ff - v_wide;
   assign diff_vu = v_wide - u_ff;

   // One restoring division step: shift in the next dividend bit and try the divisor.
   assign trial     = {rem_ff, quo_ff[W-1]};
   assign trial_ge  = trial >= u_ff;
   assign trial_sub = trial - u_ff;

   // Magnitude and denominator registers; common factors of two are stripped here.
   always_comb begin
      mag_in  = mag_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      repl_in = repl_ff;
      if (cmd.load) begin
         neg_in  = num_bits[W-1];
         mag_in  = num_bits[W-1] ? (W'(0) - num_bits) : num_bits;
         repl_in = den_bad;
         den_in  = den_bad ? D'(1) : den_bits[D-1:0];
      end else if (cmd.twos_shift) begin
         mag_in = {1'b0, mag_ff[W-1:1]};
         den_in = {1'b0, den_ff[D-1:1]};
      end
   end

   // Binary GCD of the odd part: one halving or one subtract-and-halve a cycle.
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      if (cmd.gcd_init) begin
         u_in = mag_ff;
         v_in = den_ff;
      end else if (cmd.gcd_step) begin
         if (!u_ff[0]) begin
            u_in = {1'b0, u_ff[W-1:1]};
         end else if (!v_ff[0]) begin
            v_in = {1'b0, v_ff[D-1:1]};
         end else if (u_ff > v_wide) begin
            u_in = {1'b0, diff_uv[W-1:1]};
         end else begin
            v_in = diff_vu[D:1];
         end
      end
   end

   // Shared divider: quotient shifts in from the right, remainder stays below the divisor.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.div_init_num) begin
         quo_in = mag_ff;
         rem_in = '0;
      end else if (cmd.div_init_den) begin
         quo_in = {1'b0, den_ff};
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[W-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[D-1:0] : trial[D-1:0];
      end
   end

   // Signed numerator quotient, kept while the denominator is divided.
   always_comb begin
      num_res_in = num_res_ff;
      if (cmd.save_num) begin
         num_res_in = neg_ff ? (W'(0) - quo_ff) : quo_ff;
      end
   end

   // Output register; a zero numerator returns the denominator undivided.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.reduced_numerator    = status.mag_zero ? '0 : num_res_ff;
         rsp_in.reduced_denominator  = status.mag_zero ? den_ff : quo_ff[D-1:0];
         rsp_in.denominator_replaced = repl_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      repl_ff    <= repl_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      num_res_ff <= num_res_in;
      rsp_ff     <= rsp_in;
   end

   // Status back to the controller.
   assign status.mag_zero  = (mag_ff == '0);
   assign status.both_even = !mag_ff[0] && !den_ff[0];
   assign status.gcd_equal = (u_ff == v_wide);

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== src/frac_red_ctrl.sv =====
// Controller state machine of the fraction reducer.
`default_nettype none

module frac_red_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire frac_red_pkg::status_type status,
   output frac_red_pkg::cmd_type         cmd
);

   frac_red_pkg::state_type state_ff, state_in;
   logic [frac_red_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic cnt_last;
   logic slot_free;

   assign cnt_last  = (cnt_ff == frac_red_pkg::CNT_LAST);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         frac_red_pkg::ST_IDLE: begin
            if (req_valid) state_in = frac_red_pkg::ST_TWOS;
         end
         frac_red_pkg::ST_TWOS: begin
            if (status.mag_zero) begin
               state_in = frac_red_pkg::ST_FINISH;
            end else if (!status.both_even) begin
               state_in = frac_red_pkg::ST_ODD;
            end
         end
         frac_red_pkg::ST_ODD: begin
            if (status.gcd_equal) state_in = frac_red_pkg::ST_DIVN;
         end
         frac_red_pkg::ST_DIVN: begin
            if (cnt_last) state_in = frac_red_pkg::ST_SAVEN;
         end
         frac_red_pkg::ST_SAVEN: begin
            state_in = frac_red_pkg::ST_DIVD;
         end
         frac_red_pkg::ST_DIVD: begin
            if (cnt_last) state_in = frac_red_pkg::ST_FINISH;
         end
         frac_red_pkg::ST_FINISH: begin
            if (slot_free) state_in = frac_red_pkg::ST_IDLE;
         end
         default: begin
            state_in = frac_red_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath commands for the current state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         frac_red_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         frac_red_pkg::ST_TWOS: begin
            if (!status.mag_zero) begin
               cmd.twos_shift = status.both_even;
               cmd.gcd_init   = !status.both_even;
            end
         end
         frac_red_pkg::ST_ODD: begin
            cmd.gcd_step     = !status.gcd_equal;
            cmd.div_init_num = status.gcd_equal;
         end
         frac_red_pkg::ST_DIVN: begin
            cmd.div_step = 1'b1;
         end
         frac_red_pkg::ST_SAVEN: begin
            cmd.save_num     = 1'b1;
            cmd.div_init_den = 1'b1;
         end
         frac_red_pkg::ST_DIVD: begin
            cmd.div_step = 1'b1;
         end
         frac_red_pkg::ST_FINISH: begin
            cmd.out_load = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Division step counter and response valid flag.
   assign cnt_in       = cmd.div_step ? cnt_ff + 1'b1 : '0;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frac_red_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
